// File: sv/trial_division_prime_counter_unit_assert.svh
// Assertion helpers used by the top-level RTL file.
`ifndef TRIAL_DIVISION_PRIME_COUNTER_UNIT_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TDPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdpc assertion failed");

// Next-cycle implication, checked out of reset.
`define TDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpc assertion failed");

`endif

// File: sv/tdpc_pkg.sv
`default_nettype none

package tdpc_pkg;

   localparam int VALUE_BITS  = 16;
   localparam int COUNT_BITS  = 16;
   localparam int TOTAL_BITS  = 16;
   // magnitude of a positive value: the sign bit is dropped
   localparam int MAG_BITS    = VALUE_BITS - 1;
   // (d+1)^2 for the last divisor tried stays below 2^(MAG_BITS+1)
   localparam int SQ_BITS     = MAG_BITS + 1;
   localparam int BIT_CNT_BITS = $clog2(MAG_BITS);
   localparam int CALC_BITS   = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
   // power of two, so the queue pointers wrap on their own
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   typedef enum logic {
      CLS_NOT_PRIME,
      CLS_SEARCH
   } cls_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] mag;
      cls_type             cls;
      logic                last_item;
   } item_type;

   function automatic logic [TOTAL_BITS-1:0] sat_total(input logic [COUNT_BITS-1:0] count);
      logic [CALC_BITS-1:0] wide;
      wide = CALC_BITS'(count);
      if (wide > CALC_BITS'(TOTAL_MAX)) begin
         return TOTAL_MAX;
      end else begin
         return wide[TOTAL_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/tdpc_front.sv
`default_nettype none

module tdpc_front (
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tdpc_pkg::VALUE_BITS-1:0]   req_value,
   input  wire logic                              req_last_item,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output tdpc_pkg::item_type                     push_item
);

   logic                              negative;
   logic [tdpc_pkg::MAG_BITS-1:0]     mag;

   assign negative = req_value[tdpc_pkg::VALUE_BITS-1];
   assign mag      = req_value[tdpc_pkg::VALUE_BITS-2:0];

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // negative, zero and one never enter the divisor search
   always_comb begin
      push_item.mag       = mag;
      push_item.last_item = req_last_item;
      if (negative || (mag <= tdpc_pkg::MAG_BITS'(1))) begin
         push_item.cls = tdpc_pkg::CLS_NOT_PRIME;
      end else begin
         push_item.cls = tdpc_pkg::CLS_SEARCH;
      end
   end

endmodule

`default_nettype wire

// File: sv/tdpc_queue.sv
`default_nettype none

module tdpc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire tdpc_pkg::item_type   push_item,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output tdpc_pkg::item_type        pop_item
);

   tdpc_pkg::item_type                  entry_ff [tdpc_pkg::QUEUE_DEPTH];
   logic [tdpc_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tdpc_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tdpc_pkg::QPTR_BITS:0]        fill_ff, fill_in;
   logic                                do_push, do_pop;

   assign push_ready = (fill_ff != (tdpc_pkg::QPTR_BITS+1)'(tdpc_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/tdpc_back.sv
`default_nettype none

module tdpc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire tdpc_pkg::item_type                pop_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_is_prime,
   output logic [tdpc_pkg::TOTAL_BITS-1:0]        rsp_prime_total,
   output logic                                   rsp_list_done
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIVIDE,
      ST_REMAIN,
      ST_FINISH
   } state_type;

   state_type                              state_ff, state_in;
   logic [tdpc_pkg::MAG_BITS-1:0]          mag_ff, mag_in;
   logic                                   last_ff, last_in;
   logic                                   prime_ff, prime_in;
   logic [tdpc_pkg::MAG_BITS-1:0]          div_ff, div_in;
   logic [tdpc_pkg::SQ_BITS-1:0]           dsq_ff, dsq_in;
   logic [tdpc_pkg::MAG_BITS-1:0]          rem_ff, rem_in;
   logic [tdpc_pkg::MAG_BITS-1:0]          shift_ff, shift_in;
   logic [tdpc_pkg::BIT_CNT_BITS-1:0]      bit_ff, bit_in;
   logic [tdpc_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_prime_ff, rsp_prime_in;
   logic [tdpc_pkg::TOTAL_BITS-1:0]        rsp_total_ff, rsp_total_in;
   logic                                   rsp_done_ff, rsp_done_in;

   logic [tdpc_pkg::MAG_BITS:0]            trial;
   logic [tdpc_pkg::MAG_BITS:0]            div_ext;
   logic [tdpc_pkg::MAG_BITS:0]            diff;
   logic                                   out_free;
   logic [tdpc_pkg::COUNT_BITS-1:0]        total;

   // one restoring-division step: bring down the next bit of the value
   assign trial   = {rem_ff, shift_ff[tdpc_pkg::MAG_BITS-1]};
   assign div_ext = {1'b0, div_ff};
   assign diff    = trial - div_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign total     = (prime_ff && (count_ff != tdpc_pkg::COUNT_MAX)) ?
                      count_ff + 1'b1 : count_ff;
   assign pop_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      prime_in     = prime_ff;
      div_in       = div_ff;
      dsq_in       = dsq_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_prime_in = rsp_prime_ff;
      rsp_total_in = rsp_total_ff;
      rsp_done_in  = rsp_done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               mag_in   = pop_item.mag;
               last_in  = pop_item.last_item;
               prime_in = 1'b0;
               div_in   = tdpc_pkg::MAG_BITS'(2);
               dsq_in   = tdpc_pkg::SQ_BITS'(4);
               if (pop_item.cls == tdpc_pkg::CLS_SEARCH) begin
                  state_in = ST_TEST;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_TEST: begin
            // past the square root with no divisor found
            if (dsq_ff > {1'b0, mag_ff}) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rem_in   = '0;
               shift_in = mag_ff;
               bit_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (trial >= div_ext) begin
               rem_in = diff[tdpc_pkg::MAG_BITS-1:0];
            end else begin
               rem_in = trial[tdpc_pkg::MAG_BITS-1:0];
            end
            shift_in = shift_ff << 1;
            bit_in   = bit_ff + 1'b1;
            if (bit_ff == tdpc_pkg::BIT_CNT_BITS'(tdpc_pkg::MAG_BITS - 1)) begin
               state_in = ST_REMAIN;
            end
         end
         ST_REMAIN: begin
            if (rem_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               // (d+1)^2 = d^2 + 2d + 1
               dsq_in   = dsq_ff + {div_ff, 1'b1};
               div_in   = div_ff + 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               rsp_total_in = tdpc_pkg::sat_total(total);
               rsp_done_in  = last_ff;
               count_in     = last_ff ? '0 : total;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mag_ff       <= mag_in;
         last_ff      <= last_in;
         prime_ff     <= prime_in;
         div_ff       <= div_in;
         dsq_ff       <= dsq_in;
         rem_ff       <= rem_in;
         shift_ff     <= shift_in;
         bit_ff       <= bit_in;
         rsp_prime_ff <= rsp_prime_in;
         rsp_total_ff <= rsp_total_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_prime    = rsp_prime_ff;
   assign rsp_prime_total = rsp_total_ff;
   assign rsp_list_done   = rsp_done_ff;

endmodule

`default_nettype wire

// File: sv/trial_division_prime_counter_unit.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_value, req_last_item
// rsp       out        rsp_valid/rsp_ready    rsp_is_prime, rsp_prime_total, rsp_list_done
//
// Values that are negative, zero or one skip the divisor search and go straight to a result.
// Other values try divisors 2 up to at most floor(sqrt(n)) in turn, one remainder
// bit per cycle in the restoring divider, and stop at the first exact divisor;
// the worst case is a prime near 32767.
// A two-entry queue lets req take items while the divider is busy.
// Reset is synchronous and clears the queue, the running count and rsp_valid.
`default_nettype none
`include "trial_division_prime_counter_unit_assert.svh"

module trial_division_prime_counter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tdpc_pkg::VALUE_BITS-1:0]   req_value,
   input  wire logic                              req_last_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_is_prime,
   output logic [tdpc_pkg::TOTAL_BITS-1:0]        rsp_prime_total,
   output logic                                   rsp_list_done
);

   logic                  push_valid, push_ready;
   tdpc_pkg::item_type    push_item;
   logic                  pop_valid, pop_ready;
   tdpc_pkg::item_type    pop_item;

   tdpc_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last_item (req_last_item),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   tdpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tdpc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_total (rsp_prime_total),
      .rsp_list_done   (rsp_list_done)
   );

   // a prime result always counts itself
   `TDPC_ASSERT_NOW(a_prime_counted, clock, reset, rsp_valid && rsp_is_prime, rsp_prime_total != '0)
   // a transferred request is held in the queue on the next cycle
   `TDPC_ASSERT_NEXT(a_req_queued, clock, reset, req_valid && req_ready, pop_valid)

endmodule

`default_nettype wire

// File: bench/prime_total_checker.sv
`timescale 1ns / 100ps

module prime_total_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [tdpc_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic                            req_last_item,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic                            rsp_is_prime,
   input  wire logic [tdpc_pkg::TOTAL_BITS-1:0] rsp_prime_total,
   input  wire logic                            rsp_list_done,
   output int                                   mismatches,
   output int                                   outstanding
);

   typedef struct packed {
      logic                            is_prime;
      logic [tdpc_pkg::TOTAL_BITS-1:0] prime_total;
      logic                            list_done;
   } prime_report_type;

   prime_report_type expected_reports[$];
   logic [tdpc_pkg::COUNT_BITS-1:0] list_primes = '0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // negative values, zero and one never pass; stop once d*d passes n
   function automatic logic divisor_free(input logic [tdpc_pkg::VALUE_BITS-1:0] v);
      longint unsigned n;
      longint unsigned d;
      if (v[tdpc_pkg::VALUE_BITS-1]) return 1'b0;
      n = 64'(v);
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      prime_report_type                want;
      logic                            prime;
      logic [tdpc_pkg::COUNT_BITS-1:0] total;
      if (reset) begin
         expected_reports.delete();
         list_primes = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected result: is_prime=%0b total=%0d list_done=%0b",
                           $time, rsp_is_prime, rsp_prime_total, rsp_list_done);
               end
            end else begin
               want = expected_reports.pop_front();
               if (rsp_is_prime !== want.is_prime || rsp_prime_total !== want.prime_total ||
                   rsp_list_done !== want.list_done) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch: expected is_prime=%0b total=%0d list_done=%0b",
                              $time, want.is_prime, want.prime_total, want.list_done);
                     $display("%0t:           got      is_prime=%0b total=%0d list_done=%0b",
                              $time, rsp_is_prime, rsp_prime_total, rsp_list_done);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            prime = divisor_free(req_value);
            total = list_primes;
            // hold the count at its maximum instead of wrapping
            if (prime && total != tdpc_pkg::COUNT_MAX) total = total + 1'b1;
            want.is_prime    = prime;
            want.prime_total = (64'(total) > 64'(tdpc_pkg::TOTAL_MAX)) ?
                               tdpc_pkg::TOTAL_MAX : tdpc_pkg::TOTAL_BITS'(total);
            want.list_done   = req_last_item;
            expected_reports.push_back(want);
            list_primes = req_last_item ? '0 : total;
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

// File: bench/trial_division_prime_counter_unit_tb.sv
`timescale 1ns / 100ps

module trial_division_prime_counter_unit_tb;

   localparam int CYCLE_LIMIT      = 4_000_000;
   localparam int LONG_HOLD_CYCLES = 200;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [tdpc_pkg::VALUE_BITS-1:0] req_value;
   logic                            req_last_item;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_is_prime;
   logic [tdpc_pkg::TOTAL_BITS-1:0] rsp_prime_total;
   logic                            rsp_list_done;

   int   mismatches;
   int   outstanding;
   int   cycles_run = 0;
   logic send_gaps;
   logic rsp_gaps;
   logic long_hold_req;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trial_division_prime_counter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_total (rsp_prime_total),
      .rsp_list_done   (rsp_list_done)
   );

   prime_total_checker totals_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_prime_total (rsp_prime_total),
      .rsp_list_done   (rsp_list_done),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [tdpc_pkg::VALUE_BITS-1:0] v, input logic last);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= v;
      req_last_item <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_item();
      int                              roll;
      logic [tdpc_pkg::VALUE_BITS-1:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         v = tdpc_pkg::VALUE_BITS'($urandom_range(0, 200));
      end else if (roll < 50) begin
         v = tdpc_pkg::VALUE_BITS'($urandom);
         v[tdpc_pkg::VALUE_BITS-1] = 1'b1;
      end else if (roll < 70) begin
         v = tdpc_pkg::VALUE_BITS'($urandom);
      end else if (roll < 85) begin
         v = tdpc_pkg::VALUE_BITS'($urandom_range(201, 32767));
      end else begin
         // large primes and prime squares make the longest searches
         case ($urandom_range(0, 5))
            0: v = 16'd32749;
            1: v = 16'd32719;
            2: v = 16'd32761;
            3: v = 16'd16129;
            4: v = 16'd32707;
            default: v = 16'd29929;
         endcase
      end
      send_item(v, $urandom_range(0, 5) == 0);
   endtask

   initial begin : result_side
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
            long_hold_req = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      req_last_item = 1'b0;
      send_gaps     = 1'b1;
      rsp_gaps      = 1'b1;
      long_hold_req = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, small cases, squares of primes and single-item lists
      send_item(16'h8000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd2, 1'b1);
      send_item(16'd2, 1'b1);
      send_item(16'd3, 1'b0);
      send_item(16'd4, 1'b0);
      send_item(16'd9, 1'b0);
      send_item(16'd25, 1'b0);
      send_item(16'd97, 1'b0);
      send_item(16'h7FFF, 1'b0);
      send_item(16'h7FFE, 1'b0);
      send_item(16'd32749, 1'b0);
      send_item(16'd32761, 1'b1);
      send_item(16'h8001, 1'b0);
      send_item(16'd16129, 1'b0);
      send_item(16'd121, 1'b0);
      send_item(16'd5, 1'b0);
      send_item(16'd1, 1'b1);
      send_item(16'd0, 1'b1);

      repeat (35) send_random_item();
      send_gaps = 1'b0;
      repeat (15) send_random_item();
      send_gaps = 1'b1;
      rsp_gaps  = 1'b0;
      repeat (15) send_random_item();
      rsp_gaps  = 1'b1;

      // stall results long enough for the input side to back up
      long_hold_req = 1'b1;
      repeat (8) send_item(tdpc_pkg::VALUE_BITS'($urandom_range(0, 20)),
                           $urandom_range(0, 3) == 0);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);

      // no idling from here on
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      repeat (10) send_random_item();

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
